// File: sv/mrpt_pkg.sv
// Shared constants and types for the Miller-Rabin primality tester.
package mrpt_pkg;
  localparam int WordBitsDefault = 64;
  localparam int NumSmall = 12;
  localparam int NumBases = 7;
  localparam int SmallBits = 6;
  localparam int BaseBits = 31;

  function automatic logic [SmallBits-1:0] small_prime(input logic [3:0] i);
    logic [SmallBits-1:0] p;
    unique case (i)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd1;
    endcase
    return p;
  endfunction

  function automatic logic [BaseBits-1:0] witness(input logic [2:0] i);
    logic [BaseBits-1:0] b;
    unique case (i)
      3'd0: b = 31'd2;
      3'd1: b = 31'd325;
      3'd2: b = 31'd9375;
      3'd3: b = 31'd28178;
      3'd4: b = 31'd450775;
      3'd5: b = 31'd9780504;
      3'd6: b = 31'd1795265022;
      default: b = 31'd0;
    endcase
    return b;
  endfunction

  // operation handed to the modular unit
  typedef struct packed {
    logic start;
    logic reduce;  // x mod m only (y ignored)
  } mm_cmd_t;
endpackage

// File: sv/mrpt_mulmod.sv
// Bit-serial modular multiplier: acc = x*y mod m, one multiplier bit per cycle.
module mrpt_mulmod #(
  parameter int WordBits = mrpt_pkg::WordBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  mrpt_pkg::mm_cmd_t   cmd,
  input  logic [WordBits-1:0] x,
  input  logic [WordBits-1:0] y,
  input  logic [WordBits-1:0] m,
  output logic                done,
  output logic [WordBits-1:0] result
);
  localparam int CntBits = $clog2(WordBits + 1);

  logic                busy;
  logic [CntBits-1:0]  cnt;
  logic [WordBits-1:0] xr, yr, mr, acc;
  logic [WordBits-1:0] dbl, acc_next;
  logic [WordBits:0]   sum2, sumx;

  // x operand must be below m; with reduce set, x is the value and the multiplicand is 1
  always_comb begin
    sum2 = {1'b0, acc} + {1'b0, acc};
    dbl = (sum2 >= {1'b0, mr}) ? WordBits'(sum2 - {1'b0, mr}) : WordBits'(sum2);
    sumx = {1'b0, dbl} + {1'b0, xr};
    if (yr[WordBits-1])
      acc_next = (sumx >= {1'b0, mr}) ? WordBits'(sumx - {1'b0, mr}) : WordBits'(sumx);
    else
      acc_next = dbl;
  end

  assign result = acc;

  always_ff @(posedge clk) begin
    done <= !rst && !cmd.start && busy && (cnt == CntBits'(1));
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt <= CntBits'(WordBits);
      mr <= m;
      acc <= '0;
      if (cmd.reduce) begin
        // reduce x by shifting it in a bit at a time as the multiplier
        xr <= WordBits'(1);
        yr <= x;
      end else begin
        xr <= x;
        yr <= y;
      end
    end else if (busy) begin
      acc <= acc_next;
      yr <= {yr[WordBits-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// File: sv/miller_rabin_prime_test_64.sv
// Top level of the deterministic Miller-Rabin primality tester.
// Pulse start with a candidate while busy is low; the verdict appears on
// is_prime with done high for exactly one cycle, and cannot be held off.
// Every modular product or reduction runs through one bit-serial multiplier.
// A candidate below two is rejected at once; any other is first divided by
// the twelve small primes, and one that passes goes on to the witness stage,
// which tries up to seven witness bases.
module miller_rabin_prime_test_64 #(
  parameter int WordBits = mrpt_pkg::WordBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WordBits-1:0] candidate,
  output logic                busy,
  output logic                done,
  output logic                is_prime
);
  localparam int SBits = $clog2(WordBits + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TRIAL  = 4'd1;
  localparam logic [3:0] S_WAIT_T = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_BASE   = 4'd4;
  localparam logic [3:0] S_WAIT_A = 4'd5;
  localparam logic [3:0] S_PSTEP  = 4'd6;
  localparam logic [3:0] S_WAIT_M = 4'd7;
  localparam logic [3:0] S_WAIT_S = 4'd8;
  localparam logic [3:0] S_CHECK  = 4'd9;
  localparam logic [3:0] S_SQ     = 4'd10;
  localparam logic [3:0] S_WAIT_Q = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;

  logic [3:0]          state;
  logic [WordBits-1:0] n, d, ex, r, b, nm1;
  logic [SBits-1:0]    s, k;
  logic [3:0]          pidx;
  logic [2:0]          bidx;
  logic                verdict;

  mrpt_pkg::mm_cmd_t   cmd;
  logic [WordBits-1:0] mx, my, mmod, mres;
  logic                mdone;

  mrpt_mulmod #(.WordBits(WordBits)) u_mm (
    .clk(clk), .rst(rst), .cmd(cmd), .x(mx), .y(my), .m(mmod),
    .done(mdone), .result(mres)
  );

  assign busy = (state != S_IDLE);
  assign nm1 = n - WordBits'(1);

  // issue multiplier commands on the edge that leaves the issuing state
  always_comb begin
    cmd = '0;
    mx = r;
    my = b;
    mmod = n;
    unique case (state)
      S_TRIAL: begin
        // reduce n modulo the current small prime
        mx = n;
        mmod = WordBits'(mrpt_pkg::small_prime(pidx));
        cmd = '{start: 1'b1, reduce: 1'b1};
      end
      S_BASE: begin
        mx = WordBits'(mrpt_pkg::witness(bidx));
        cmd = '{start: 1'b1, reduce: 1'b1};
      end
      S_PSTEP: begin
        if (ex != '0) begin
          mx = ex[0] ? r : b;
          my = b;
          cmd = '{start: 1'b1, reduce: 1'b0};
        end
      end
      S_WAIT_M: begin
        if (mdone) begin
          mx = b;
          my = b;
          cmd = '{start: 1'b1, reduce: 1'b0};
        end
      end
      S_SQ: begin
        if (k < s) begin
          mx = r;
          my = r;
          cmd = '{start: 1'b1, reduce: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_FINISH);
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n <= candidate;
            pidx <= '0;
            if (candidate < WordBits'(2)) begin
              verdict <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_TRIAL;
            end
          end
        end
        S_TRIAL: begin
          state <= S_WAIT_T;
        end
        S_WAIT_T: begin
          if (mdone) begin
            if (mres == '0) begin
              verdict <= (n == WordBits'(mrpt_pkg::small_prime(pidx)));
              state <= S_FINISH;
            end else if (pidx == 4'(mrpt_pkg::NumSmall - 1)) begin
              d <= nm1;
              s <= '0;
              state <= S_SPLIT;
            end else begin
              pidx <= pidx + 1'b1;
              state <= S_TRIAL;
            end
          end
        end
        S_SPLIT: begin
          // strip one trailing zero per cycle
          if (d[0]) begin
            bidx <= '0;
            state <= S_BASE;
          end else begin
            d <= d >> 1;
            s <= s + 1'b1;
          end
        end
        S_BASE: begin
          state <= S_WAIT_A;
        end
        S_WAIT_A: begin
          if (mdone) begin
            if (mres == '0) begin
              if (bidx == 3'(mrpt_pkg::NumBases - 1)) begin
                verdict <= 1'b1;
                state <= S_FINISH;
              end else begin
                bidx <= bidx + 1'b1;
                state <= S_BASE;
              end
            end else begin
              b <= mres;
              r <= WordBits'(1);
              ex <= d;
              state <= S_PSTEP;
            end
          end
        end
        S_PSTEP: begin
          if (ex == '0) begin
            k <= SBits'(1);
            state <= S_CHECK;
          end else if (ex[0]) begin
            state <= S_WAIT_M;
          end else begin
            state <= S_WAIT_S;
          end
        end
        S_WAIT_M: begin
          if (mdone) begin
            r <= mres;
            state <= S_WAIT_S;
          end
        end
        S_WAIT_S: begin
          if (mdone) begin
            b <= mres;
            ex <= ex >> 1;
            state <= S_PSTEP;
          end
        end
        S_CHECK: begin
          if (r == WordBits'(1) || r == nm1) begin
            if (bidx == 3'(mrpt_pkg::NumBases - 1)) begin
              verdict <= 1'b1;
              state <= S_FINISH;
            end else begin
              bidx <= bidx + 1'b1;
              state <= S_BASE;
            end
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k >= s) begin
            verdict <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_WAIT_Q;
          end
        end
        S_WAIT_Q: begin
          if (mdone) begin
            k <= k + 1'b1;
            if (mres == nm1) begin
              r <= WordBits'(1);
              state <= S_CHECK;
            end else begin
              r <= mres;
              state <= S_SQ;
            end
          end
        end
        S_FINISH: begin
          is_prime <= verdict;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
